>>> rtl/core/assert_macros.svh
// Assertion helpers, clocked on rising edge with reset masking by disable iff.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante |-> cons in the same cycle
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// ante |=> cons in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/core/brda_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package brda_pkg;

  localparam int SPAN_W    = 28;
  localparam int AMT_W     = 21;
  localparam int DIV_STEPS = SPAN_W;
  localparam int TABLES    = 6;

  localparam logic [AMT_W-1:0] MIN_BIN_WIDTH = 21'd10;
  localparam logic [11:0]      SKIP_FLAGS    = 12'h100 | 12'h400 | 12'h800;

  localparam logic CMD_ADD  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FILTERED  = 3'd1;
  localparam logic [2:0] ST_BAD_CHROM = 3'd2;
  localparam logic [2:0] ST_BAD_SPAN  = 3'd3;
  localparam logic [2:0] ST_BIN_DATA  = 3'd4;

  localparam logic [1:0] CFG_BIN_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_QUAL_CUTOFF = 2'd1;
  localparam logic [1:0] CFG_CHROM_COUNT = 2'd2;

  localparam logic [1:0] HAP_ONE = 2'd1;
  localparam logic [1:0] HAP_TWO = 2'd2;

  typedef struct packed {
    logic              command;
    logic [4:0]        chromosome;
    logic [SPAN_W-1:0] span_start;
    logic [SPAN_W-1:0] span_end;
    logic [7:0]        map_quality;
    logic [1:0]        haplotype;
    logic [11:0]       read_flags;
    logic [9:0]        bin_number;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] unphased_high;
    logic [31:0] unphased_low;
    logic [31:0] hap_one_high;
    logic [31:0] hap_one_low;
    logic [31:0] hap_two_high;
    logic [31:0] hap_two_low;
  } rsp_t;

endpackage

`default_nettype wire

>>> rtl/core/binned_read_depth_accumulator.sv
// Channel  Dir  Handshake              Word
// req      in   req_valid / req_stall  req_t: command and read record
// rsp      out  rsp_valid / rsp_stall  rsp_t: status and six bin counts
// cfg      in   cfg_valid / cfg_ready  cfg_index, cfg_data (always ready)
//
// Add: divide span start, then span end, by the bin width, one quotient bit a
//   cycle; then per bin touched a read, then a saturating write; then the result.
// Read out: memory read, then the result. Filtered, bad chromosome or reversed
//   span: straight to the result; last bin past the store: both divides, then the result.
// After reset a clearing pass zeroes one row a cycle, all 2^(clog2(MAX_CHROMOSOMES)
//   + clog2(BINS_PER_CHROMOSOME)) rows (32768 by default); req_stall is held.
// The result register lets the next word in while a result waits; a result
//   finishing behind a stalled one waits in the response state.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module binned_read_depth_accumulator
  import brda_pkg::*;
#(
  parameter int MAX_CHROMOSOMES     = 32,
  parameter int BINS_PER_CHROMOSOME = 1024,
  parameter int COUNT_BITS          = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        req_valid,
  output logic             req_stall,
  input  wire req_t        req,
  output logic             rsp_valid,
  input  wire logic        rsp_stall,
  output rsp_t             rsp,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [20:0] cfg_data
);

  localparam int CH_AW  = (MAX_CHROMOSOMES > 1) ? $clog2(MAX_CHROMOSOMES) : 1;
  localparam int BIN_AW = $clog2(BINS_PER_CHROMOSOME);
  localparam int AW     = CH_AW + BIN_AW;
  localparam int DEPTH  = 1 << AW;
  localparam int ROW_W  = TABLES * COUNT_BITS;
  localparam int SUM_W  = ((COUNT_BITS > AMT_W) ? COUNT_BITS : AMT_W) + 1;
  localparam int CNT_W  = $clog2(DIV_STEPS);
  localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_DIV_S, S_DIV_E, S_MEM_RD, S_BIN_RD, S_BIN_WR, S_RESP
  } state_t;

  state_t state;

  logic [AMT_W-1:0]  bin_width;
  logic [5:0]        quality_cutoff;
  logic [5:0]        chromosome_count;

  logic [CH_AW-1:0]  chrom_idx;
  logic [SPAN_W-1:0] span_s, span_e;
  logic [2:0]        tbl;
  logic [BIN_AW-1:0] first_bin, last_bin, bin_k;
  logic [AMT_W-1:0]  srem, erem;
  logic [SPAN_W-1:0] quo;
  logic [AMT_W-1:0]  rem;
  logic [CNT_W-1:0]  div_cnt;
  logic [2:0]        status_r;
  logic [AW-1:0]     clr_addr;

  logic [ROW_W-1:0]  mem [DEPTH];
  logic [ROW_W-1:0]  rd_data;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [ROW_W-1:0]  wr_data;

  logic [AMT_W-1:0]  weff;
  logic [AMT_W:0]    div_sh, div_diff;
  logic              div_ge;
  logic [AMT_W-1:0]  rem_next;
  logic [SPAN_W-1:0] quo_next;

  logic              bad_chrom, bad_bin, skip;
  logic [2:0]        tbl_in;

  logic [AMT_W-1:0]      amount;
  logic [COUNT_BITS-1:0] cur;
  logic [SUM_W-1:0]      sum;
  logic [COUNT_BITS-1:0] sat;
  logic [ROW_W-1:0]      row_new;

  assign cfg_ready = 1'b1;
  assign req_stall = (state != S_IDLE);

  assign weff = (bin_width < MIN_BIN_WIDTH) ? MIN_BIN_WIDTH : bin_width;

  // one restoring divide step
  assign div_sh   = {rem, quo[SPAN_W-1]};
  assign div_diff = div_sh - {1'b0, weff};
  assign div_ge   = (div_sh >= {1'b0, weff});
  assign rem_next = div_ge ? div_diff[AMT_W-1:0] : div_sh[AMT_W-1:0];
  assign quo_next = {quo[SPAN_W-2:0], div_ge};

  assign bad_chrom = ({1'b0, req.chromosome} >= chromosome_count) ||
                     ({27'd0, req.chromosome} >= 32'(MAX_CHROMOSOMES));
  assign bad_bin   = ({22'd0, req.bin_number} >= 32'(BINS_PER_CHROMOSOME));
  assign skip      = |(req.read_flags & SKIP_FLAGS);

  always_comb begin
    if (req.haplotype == HAP_ONE) begin
      tbl_in = 3'd2;
    end else if (req.haplotype == HAP_TWO) begin
      tbl_in = 3'd4;
    end else begin
      tbl_in = 3'd0;
    end
    if (req.map_quality < {2'b00, quality_cutoff}) begin
      tbl_in = tbl_in + 3'd1;
    end
  end

  always_comb begin
    if (first_bin == last_bin) begin
      amount = AMT_W'(span_e - span_s);
    end else if (bin_k == first_bin) begin
      amount = weff - srem;
    end else if (bin_k == last_bin) begin
      amount = erem;
    end else begin
      amount = weff;
    end
    cur = rd_data[tbl*COUNT_BITS +: COUNT_BITS];
    sum = SUM_W'(cur) + SUM_W'(amount);
    sat = (sum > SUM_W'(CNT_MAX)) ? CNT_MAX : COUNT_BITS'(sum);
    for (int j = 0; j < TABLES; j++) begin
      row_new[j*COUNT_BITS +: COUNT_BITS] =
        (3'(j) == tbl) ? sat : rd_data[j*COUNT_BITS +: COUNT_BITS];
    end
  end

  assign rd_en   = (state == S_MEM_RD) || (state == S_BIN_RD);
  assign rd_addr = {chrom_idx, bin_k};
  assign wr_en   = (state == S_CLEAR) || (state == S_BIN_WR);
  assign wr_addr = (state == S_CLEAR) ? clr_addr : {chrom_idx, bin_k};
  assign wr_data = (state == S_CLEAR) ? '0 : row_new;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_addr         <= '0;
      rsp_valid        <= 1'b0;
      bin_width        <= 21'd1000;
      quality_cutoff   <= 6'd20;
      chromosome_count <= 6'd32;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          CFG_BIN_WIDTH:   bin_width        <= cfg_data;
          CFG_QUAL_CUTOFF: quality_cutoff   <= cfg_data[5:0];
          CFG_CHROM_COUNT: chromosome_count <= cfg_data[5:0];
          default: ;
        endcase
      end

      if (rsp_valid && !rsp_stall && (state != S_RESP)) begin
        rsp_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_valid) begin
            chrom_idx <= CH_AW'(req.chromosome);
            span_s    <= req.span_start;
            span_e    <= req.span_end;
            tbl       <= tbl_in;
            bin_k     <= BIN_AW'(req.bin_number);
            quo       <= req.span_start;
            rem       <= '0;
            div_cnt   <= '0;
            if (bad_chrom) begin
              status_r <= ST_BAD_CHROM;
              state    <= S_RESP;
            end else if (req.command == CMD_READ) begin
              if (bad_bin) begin
                status_r <= ST_BAD_SPAN;
                state    <= S_RESP;
              end else begin
                status_r <= ST_BIN_DATA;
                state    <= S_MEM_RD;
              end
            end else if (skip) begin
              status_r <= ST_FILTERED;
              state    <= S_RESP;
            end else if (req.span_end < req.span_start) begin
              status_r <= ST_BAD_SPAN;
              state    <= S_RESP;
            end else begin
              status_r <= ST_ADDED;
              state    <= S_DIV_S;
            end
          end
        end
        S_DIV_S: begin
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
            first_bin <= BIN_AW'(quo_next);
            srem      <= rem_next;
            quo       <= span_e;
            rem       <= '0;
            div_cnt   <= '0;
            state     <= S_DIV_E;
          end else begin
            div_cnt <= div_cnt + 1'b1;
            quo     <= quo_next;
            rem     <= rem_next;
          end
        end
        S_DIV_E: begin
          div_cnt <= div_cnt + 1'b1;
          quo     <= quo_next;
          rem     <= rem_next;
          if (div_cnt == CNT_W'(DIV_STEPS - 1)) begin
            last_bin <= BIN_AW'(quo_next);
            erem     <= rem_next;
            bin_k    <= first_bin;
            if (quo_next >= SPAN_W'(BINS_PER_CHROMOSOME)) begin
              status_r <= ST_BAD_SPAN;
              state    <= S_RESP;
            end else begin
              state <= S_BIN_RD;
            end
          end
        end
        S_MEM_RD: begin
          state <= S_RESP;
        end
        S_BIN_RD: begin
          state <= S_BIN_WR;
        end
        S_BIN_WR: begin
          if (bin_k == last_bin) begin
            state <= S_RESP;
          end else begin
            bin_k <= bin_k + 1'b1;
            state <= S_BIN_RD;
          end
        end
        S_RESP: begin
          if (!rsp_valid || !rsp_stall) begin
            rsp_valid  <= 1'b1;
            rsp.status <= status_r;
            if (status_r == ST_BIN_DATA) begin
              rsp.unphased_high <= 32'(rd_data[0*COUNT_BITS +: COUNT_BITS]);
              rsp.unphased_low  <= 32'(rd_data[1*COUNT_BITS +: COUNT_BITS]);
              rsp.hap_one_high  <= 32'(rd_data[2*COUNT_BITS +: COUNT_BITS]);
              rsp.hap_one_low   <= 32'(rd_data[3*COUNT_BITS +: COUNT_BITS]);
              rsp.hap_two_high  <= 32'(rd_data[4*COUNT_BITS +: COUNT_BITS]);
              rsp.hap_two_low   <= 32'(rd_data[5*COUNT_BITS +: COUNT_BITS]);
            end else begin
              rsp.unphased_high <= '0;
              rsp.unphased_low  <= '0;
              rsp.hap_one_high  <= '0;
              rsp.hap_one_low   <= '0;
              rsp.hap_two_high  <= '0;
              rsp.hap_two_low   <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && !req_stall, req_stall)
  `ASSERT_SAME(a_bin_in_span, clk, rst, (state == S_BIN_RD) || (state == S_BIN_WR), (bin_k >= first_bin) && (bin_k <= last_bin))
  `ASSERT_SAME(a_result_from_resp, clk, rst, $rose(rsp_valid), $past(state) == S_RESP)
  `ASSERT_SAME(a_clear_quiet, clk, rst, state == S_CLEAR, req_stall && !rsp_valid)

endmodule

`default_nettype wire
